### src/zde_pkg.sv
// ----------------------------------------------------------------------------
// zde_pkg
// Shared widths and the Fibonacci weight function for the Zeckendorf encoder.
// ----------------------------------------------------------------------------
package zde_pkg;

	// fixed width of the input field
	localparam int N_VALUE_W = 32;

	// widest weight needed: the largest supported term still fits in 48 bits
	localparam int WEIGHT_W = 48;

	localparam int DEF_VALUE_WIDTH = 32;
	localparam int DEF_NUM_TERMS   = 46;

	// entries in the front-to-back queue
	localparam int QUEUE_DEPTH = 2;

	// weight k: 1, 2, 3, 5, 8, ... (evaluated at elaboration only)
	function automatic logic [WEIGHT_W-1:0] fib_weight(input int k);
		longint unsigned a;
		longint unsigned b;
		longint unsigned t;
		a = 64'd1;
		b = 64'd2;
		for (int i = 0; i < k; i++) begin
			t = a + b;
			a = b;
			b = t;
		end
		return a[WEIGHT_W-1:0];
	endfunction

endpackage

### src/zde_front.sv
// ----------------------------------------------------------------------------
// zde_front
// Accepts a value and searches upward for the largest weight not above it.
// ----------------------------------------------------------------------------
module zde_front #(
	parameter int VALUE_WIDTH = zde_pkg::DEF_VALUE_WIDTH,
	parameter int NUM_TERMS   = zde_pkg::DEF_NUM_TERMS,
	parameter int TERM_W      = $clog2(NUM_TERMS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [zde_pkg::N_VALUE_W-1:0] n_value,
	output logic                          push,
	output logic [VALUE_WIDTH+TERM_W-1:0] push_data,
	input  logic                          full
);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_SEARCH = 1'b1;

	logic [zde_pkg::WEIGHT_W-1:0] weights [NUM_TERMS];

	for (genvar g = 0; g < NUM_TERMS; g++) begin : g_weight
		assign weights[g] = zde_pkg::fib_weight(g);
	end

	logic                   state_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [TERM_W-1:0]      top_q;
	logic [TERM_W:0]        next_idx;
	logic                   grow;
	logic                   accept;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign next_idx   = {1'b0, top_q} + 1'b1;

	// the next weight still fits, so the top term moves up
	assign grow = (next_idx < (TERM_W+1)'(NUM_TERMS))
		&& (weights[next_idx[TERM_W-1:0]] <= zde_pkg::WEIGHT_W'(val_q));

	assign push      = (state_q == ST_SEARCH) && !grow && !full;
	assign push_data = {val_q, top_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			top_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SEARCH;
						top_q   <= '0;
					end
				end
				ST_SEARCH: begin
					if (grow) begin
						top_q <= next_idx[TERM_W-1:0];
					end else if (!full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= VALUE_WIDTH'(n_value);
		end
	end

	a_push_only_searching: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (state_q == ST_SEARCH) && !full)
		else $error("front pushed outside search or into full queue");

	a_top_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(push && val_q != '0) |-> (weights[top_q] <= zde_pkg::WEIGHT_W'(val_q)))
		else $error("top weight exceeds value");

	a_top_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (top_q < TERM_W'(NUM_TERMS)))
		else $error("top index out of range");

endmodule

### src/zde_queue.sv
// ----------------------------------------------------------------------------
// zde_queue
// Small register queue between the search front and the digit back end.
// ----------------------------------------------------------------------------
module zde_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = $clog2(zde_pkg::QUEUE_DEPTH);

	logic [WIDTH-1:0] mem_q [zde_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == (PTR_W+1)'(zde_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(zde_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(zde_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(zde_pkg::QUEUE_DEPTH))
		else $error("queue count overflow");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

### src/zde_back.sv
// ----------------------------------------------------------------------------
// zde_back
// Walks down from the top weight, one compare and subtract per digit.
// ----------------------------------------------------------------------------
module zde_back #(
	parameter int VALUE_WIDTH = zde_pkg::DEF_VALUE_WIDTH,
	parameter int NUM_TERMS   = zde_pkg::DEF_NUM_TERMS,
	parameter int TERM_W      = $clog2(NUM_TERMS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	output logic                          pop,
	input  logic [VALUE_WIDTH+TERM_W-1:0] pop_data,
	input  logic                          empty,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          digit,
	output logic                          last
);

	logic [zde_pkg::WEIGHT_W-1:0] weights [NUM_TERMS];

	for (genvar g = 0; g < NUM_TERMS; g++) begin : g_weight
		assign weights[g] = zde_pkg::fib_weight(g);
	end

	logic                   busy_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [TERM_W-1:0]      k_q;
	logic                   valid_q;
	logic                   digit_q;
	logic                   last_q;
	logic                   prev_one_q;
	logic                   out_free;
	logic                   advance;
	logic                   fits;
	logic                   is_last;

	assign out_free = !valid_q || !result_stall;
	assign advance  = busy_q && out_free;
	assign fits     = weights[k_q] <= zde_pkg::WEIGHT_W'(rem_q);
	assign is_last  = (k_q == '0);
	// next item loads in the cycle the current one gives its last digit
	assign pop      = !empty && (!busy_q || (advance && is_last));

	assign result_valid = valid_q;
	assign digit        = digit_q;
	assign last         = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			valid_q    <= 1'b0;
			prev_one_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (advance && is_last) begin
				busy_q <= 1'b0;
			end
			if (advance) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
			if (valid_q && !result_stall) begin
				prev_one_q <= digit_q && !last_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rem_q <= pop_data[VALUE_WIDTH+TERM_W-1:TERM_W];
			k_q   <= pop_data[TERM_W-1:0];
		end else if (advance) begin
			if (fits) begin
				rem_q <= rem_q - VALUE_WIDTH'(weights[k_q]);
			end
			k_q <= k_q - 1'b1;
		end
		if (advance) begin
			digit_q <= fits;
			last_q  <= is_last;
		end
	end

	a_no_adjacent_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && digit_q) |-> !prev_one_q)
		else $error("two adjacent one digits");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && valid_q && result_stall) |=> $stable(k_q) && $stable(rem_q))
		else $error("walk advanced while output stalled");

	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_last && !pop) |=> !busy_q)
		else $error("back end still busy after last digit");

endmodule

### src/zeckendorf_digit_encoder.sv
// ----------------------------------------------------------------------------
// zeckendorf_digit_encoder
// Converts an unsigned value into Zeckendorf digits, most significant first.
// ----------------------------------------------------------------------------
// usage:
//   item channel: item_valid / item_stall / n_value. one value per transfer,
//   only its low VALUE_WIDTH bits count.
//   result channel: result_valid / result_stall / digit / last. one digit per
//   transfer, largest weight first; last marks the weight-1 digit. a zero
//   value gives a single 0 digit with last set.
//   front: after a transfer the front steps up the weight table one term per
//   cycle and stalls the item channel until it has queued the value with its
//   top, the index of the largest weight not above it (at most NUM_TERMS-1).
//   back: a two-entry queue feeds the back end, which gives top+1 digits
//   through a registered output, one per cycle while result_stall is low.
//   the front search and the back digit walk overlap across items.
//   result_stall holds the output register and freezes the back end; the
//   queue then fills and the front stalls the item channel.
//   reset clears the queue, both control state machines and the output valid.
// ----------------------------------------------------------------------------
module zeckendorf_digit_encoder #(
	parameter int VALUE_WIDTH = zde_pkg::DEF_VALUE_WIDTH,
	parameter int NUM_TERMS   = zde_pkg::DEF_NUM_TERMS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [zde_pkg::N_VALUE_W-1:0] n_value,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          digit,
	output logic                          last
);

	localparam int TERM_W = $clog2(NUM_TERMS);
	localparam int ENTRY_W = VALUE_WIDTH + TERM_W;

	logic               push;
	logic [ENTRY_W-1:0] push_data;
	logic               full;
	logic               pop;
	logic [ENTRY_W-1:0] pop_data;
	logic               empty;

	zde_front #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.NUM_TERMS  (NUM_TERMS),
		.TERM_W     (TERM_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.n_value   (n_value),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	zde_queue #(
		.WIDTH(ENTRY_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (empty)
	);

	zde_back #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.NUM_TERMS  (NUM_TERMS),
		.TERM_W     (TERM_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop         (pop),
		.pop_data    (pop_data),
		.empty       (empty),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.digit       (digit),
		.last        (last)
	);

endmodule

### sim/zeckendorf_digit_encoder_tb.sv
// ----------------------------------------------------------------------------
// zeckendorf_digit_encoder_tb
// Self-checking bench for the Zeckendorf digit encoder. Values are pushed
// through the item channel, and a greedy Fibonacci decomposition in the bench
// predicts every digit and last flag. Each result transfer is checked in order.
// Directed corner values come first, then random values under several mixes of
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module zeckendorf_digit_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VALUE_W     = zde_pkg::DEF_VALUE_WIDTH;
	localparam int TERMS       = zde_pkg::DEF_NUM_TERMS;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int TAIL_CYCLES = 64;
	localparam int MAX_REPORTS = 100;

	typedef struct packed {
		logic digit;
		logic last;
	} zeck_digit_t;

	logic                          clk;
	logic                          arst_n       = 1'b0;
	logic                          item_valid   = 1'b0;
	logic                          item_stall;
	logic [zde_pkg::N_VALUE_W-1:0] n_value      = '0;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	logic                          digit;
	logic                          last;

	zeck_digit_t     pending_digits[$];
	longint unsigned fib_tbl[TERMS];
	int              tx_max_gap   = 0;
	int              rx_max_stall = 0;
	int              stall_left   = 0;
	int              errors       = 0;
	int              cycle_count  = 0;

	zeckendorf_digit_encoder #(
		.VALUE_WIDTH(VALUE_W),
		.NUM_TERMS  (TERMS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.n_value     (n_value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.digit       (digit),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	function automatic void build_fib_table();
		fib_tbl[0] = 64'd1;
		fib_tbl[1] = 64'd2;
		for (int k = 2; k < TERMS; k++)
			fib_tbl[k] = fib_tbl[k-1] + fib_tbl[k-2];
	endfunction

	// greedy decomposition, largest weight first
	function automatic void predict_zeckendorf(input logic [zde_pkg::N_VALUE_W-1:0] value);
		longint unsigned rest;
		int              top;
		zeck_digit_t     d;
		rest = value;
		if (VALUE_W < 64)
			rest = rest & ((64'd1 << VALUE_W) - 64'd1);
		if (rest == 0) begin
			d.digit = 1'b0;
			d.last  = 1'b1;
			pending_digits = {pending_digits, d};
			return;
		end
		top = 0;
		while (top + 1 < TERMS && fib_tbl[top+1] <= rest)
			top++;
		for (int k = top; k >= 0; k--) begin
			d.digit = 1'b0;
			if (fib_tbl[k] <= rest) begin
				rest    = rest - fib_tbl[k];
				d.digit = 1'b1;
			end
			d.last = (k == 0);
			pending_digits = {pending_digits, d};
		end
	endfunction

	// valid is left high after a transfer so back-to-back items never glitch it
	task automatic send_value(input logic [zde_pkg::N_VALUE_W-1:0] value);
		int gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		n_value    <= value;
		do
			@(posedge clk);
		while (item_stall);
		predict_zeckendorf(value);
	endtask

	// drop valid first so the last value is not taken a second time
	task automatic wait_all_digits();
		item_valid <= 1'b0;
		while (pending_digits.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [zde_pkg::N_VALUE_W-1:0] random_value();
		longint unsigned w;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 200);
			2: return $urandom >> $urandom_range(1, 31);
			default: begin
				// land on or right next to a weight
				w = fib_tbl[$urandom_range(0, TERMS - 1)] + $urandom_range(0, 2) - 1;
				return w[zde_pkg::N_VALUE_W-1:0];
			end
		endcase
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_value(random_value());
	endtask

	// result side: compare each transfer against the oldest prediction, then maybe stall at random
	always @(posedge clk) begin
		zeck_digit_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_digits.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result digit %0b last %0b", $time, digit, last);
			end else begin
				want = pending_digits.pop_front();
				if (digit !== want.digit) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: digit mismatch, expected %0b actual %0b",
							$time, want.digit, digit);
				end
				if (last !== want.last) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: last mismatch, expected %0b actual %0b",
							$time, want.last, last);
				end
			end
			stall_left = $urandom_range(0, rx_max_stall);
		end else if (stall_left > 0) begin
			stall_left--;
		end
		result_stall <= (stall_left > 0);
	end

	task automatic test_directed_values();
		logic [zde_pkg::N_VALUE_W-1:0] vals[$];
		tx_max_gap   = 3;
		rx_max_stall = 3;
		vals = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd12,
			32'd100, 32'd0, 32'hFFFF_FFFF, 32'd2971215073, 32'd2971215072,
			32'd2971215074, 32'd1836311903, 32'd1836311902, 32'hAAAA_AAAA,
			32'h5555_5555, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1};
		foreach (vals[i])
			send_value(vals[i]);
	endtask

	task automatic test_back_to_back();
		tx_max_gap   = 0;
		rx_max_stall = 0;
		send_random(100);
	endtask

	task automatic test_output_backpressure();
		tx_max_gap   = 0;
		rx_max_stall = 13;
		send_random(90);
	endtask

	task automatic test_idle_both_sides();
		tx_max_gap   = 13;
		rx_max_stall = 13;
		send_random(90);
	endtask

	// sender holds off until the block has delivered everything
	task automatic test_drain_between_bursts();
		tx_max_gap   = 2;
		rx_max_stall = 4;
		for (int b = 0; b < 6; b++) begin
			send_random(10);
			wait_all_digits();
		end
	endtask

	task automatic test_mixed_idling();
		for (int b = 0; b < 10; b++) begin
			tx_max_gap   = $urandom_range(0, 13);
			rx_max_stall = $urandom_range(0, 13);
			send_random(11);
		end
	endtask

	initial begin
		build_fib_table();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_values();
		test_back_to_back();
		test_output_backpressure();
		test_idle_both_sides();
		test_drain_between_bursts();
		test_mixed_idling();
		wait_all_digits();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### sim.f
src/zde_pkg.sv
src/zde_front.sv
src/zde_queue.sv
src/zde_back.sv
src/zeckendorf_digit_encoder.sv
sim/zeckendorf_digit_encoder_tb.sv
